// ===== rtl/core/rsth_pkg.sv =====
// Shared types, widths and helpers for the ray segment / triangle hit unit.
// Used by the multiply-accumulate unit, the divider and the top level.
`timescale 1ns / 1ps

package rsth_pkg;

  // Coordinate, difference and wide operand widths
  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int LimbW  = 32;
  localparam int AW     = 104;
  localparam int AccW   = 140;
  localparam int ProdW  = 2 * DiffW;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
    logic                     last_triangle;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
    logic                     hit_found;
  } out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic signed [DiffW-1:0] x;
    logic signed [DiffW-1:0] y;
    logic signed [DiffW-1:0] z;
  } dvec_t;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
  } wvec_t;

  // One request to the shared multiply-accumulate unit
  typedef struct packed {
    logic signed [AW-1:0]    a;
    logic signed [DiffW-1:0] b;
    logic [2:0]              limbs;
    logic                    neg;
    logic                    clr;
  } mac_req_t;

  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_FAR_X   = 3'd3,
    CFG_FAR_Y   = 3'd4,
    CFG_FAR_Z   = 3'd5
  } cfg_idx_t;

  function automatic logic signed [CoordW-1:0] cpick(input cvec_t v, input logic [1:0] i);
    logic signed [CoordW-1:0] r;
    case (i)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  function automatic logic signed [DiffW-1:0] dpick(input dvec_t v, input logic [1:0] i);
    logic signed [DiffW-1:0] r;
    case (i)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  function automatic logic signed [AW-1:0] wpick(input wvec_t v, input logic [1:0] i);
    logic signed [AW-1:0] r;
    case (i)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  function automatic wvec_t wset(input wvec_t v, input logic [1:0] i,
                                 input logic signed [AW-1:0] val);
    wvec_t r;
    r = v;
    case (i)
      2'd0:    r.x = val;
      2'd1:    r.y = val;
      default: r.z = val;
    endcase
    return r;
  endfunction

  // Operand axes of one cross product term: component c, second term flag
  function automatic logic [1:0] cross_a(input logic [1:0] c, input logic second);
    logic [1:0] r;
    case (c)
      2'd0:    r = second ? 2'd2 : 2'd1;
      2'd1:    r = second ? 2'd0 : 2'd2;
      default: r = second ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_b(input logic [1:0] c, input logic second);
    logic [1:0] r;
    case (c)
      2'd0:    r = second ? 2'd1 : 2'd2;
      2'd1:    r = second ? 2'd2 : 2'd0;
      default: r = second ? 2'd0 : 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [DiffW-1:0] dsub(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
    return {a[CoordW-1], a} - {b[CoordW-1], b};
  endfunction

  function automatic dvec_t vsub(input cvec_t a, input cvec_t b);
    dvec_t r;
    r.x = dsub(a.x, b.x);
    r.y = dsub(a.y, b.y);
    r.z = dsub(a.z, b.z);
    return r;
  endfunction

  function automatic logic signed [AW-1:0] wext(input logic signed [DiffW-1:0] d);
    return {{(AW-DiffW){d[DiffW-1]}}, d};
  endfunction

endpackage

// ===== rtl/core/rsth_mac.sv =====
// Shared multiply-accumulate unit: wide signed operand times 33-bit signed,
// one 32-bit limb per cycle, added to or subtracted from an accumulator.
// Depends on rsth_pkg.
`timescale 1ns / 1ps

module rsth_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  rsth_pkg::mac_req_t                 req,
  output logic                               done,
  output logic signed [rsth_pkg::AccW-1:0]   acc
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DRAIN, M_ACC} mstate_t;

  mstate_t                                state_r;
  logic signed [rsth_pkg::AW-1:0]         a_r;
  logic signed [rsth_pkg::DiffW-1:0]      b_r;
  logic                                   neg_r;
  logic                                   clr_r;
  logic [1:0]                             cnt_r;
  logic [1:0]                             top_r;
  logic signed [rsth_pkg::ProdW-1:0]      prod_r;
  logic                                   pv_r;
  logic signed [rsth_pkg::AccW-1:0]       psum_r;
  logic signed [rsth_pkg::AccW-1:0]       acc_r;
  logic                                   done_r;

  logic signed [rsth_pkg::AW-1:0]         shifted;
  logic signed [rsth_pkg::DiffW-1:0]      limb;
  logic signed [rsth_pkg::ProdW-1:0]      prod_nxt;
  logic signed [rsth_pkg::AccW-1:0]       psum_nxt;
  logic signed [rsth_pkg::AccW-1:0]       base;

  // Select limb: top limb signed, lower limbs unsigned
  always_comb begin
    shifted  = a_r >>> {cnt_r, 5'b00000};
    limb     = (cnt_r == top_r) ? shifted[rsth_pkg::DiffW-1:0]
                                : {1'b0, shifted[rsth_pkg::LimbW-1:0]};
    prod_nxt = limb * b_r;
    psum_nxt = (psum_r <<< rsth_pkg::LimbW)
             + {{(rsth_pkg::AccW-rsth_pkg::ProdW){prod_r[rsth_pkg::ProdW-1]}}, prod_r};
    base     = clr_r ? '0 : acc_r;
  end

  // Sequence limbs from the top, Horner style
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= req.a;
            b_r     <= req.b;
            neg_r   <= req.neg;
            clr_r   <= req.clr;
            cnt_r   <= 2'(req.limbs - 3'd1);
            top_r   <= 2'(req.limbs - 3'd1);
            psum_r  <= '0;
            pv_r    <= 1'b0;
            state_r <= M_MUL;
          end
        end
        M_MUL: begin
          prod_r <= prod_nxt;
          pv_r   <= 1'b1;
          if (pv_r) psum_r <= psum_nxt;
          if (cnt_r == 2'd0) state_r <= M_DRAIN;
          else cnt_r <= cnt_r - 2'd1;
        end
        M_DRAIN: begin
          psum_r  <= psum_nxt;
          state_r <= M_ACC;
        end
        M_ACC: begin
          acc_r   <= neg_r ? (base - psum_r) : (base + psum_r);
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

// ===== rtl/core/rsth_div.sv =====
// Restoring fraction divider: floor(num * 2^32 / den) for num < den,
// one quotient bit per cycle. Depends on rsth_pkg.
`timescale 1ns / 1ps

module rsth_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rsth_pkg::AW-1:0]   num,
  input  logic [rsth_pkg::AW-1:0]   den,
  output logic                      done,
  output logic [31:0]               q
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                  state_r;
  logic [rsth_pkg::AW:0]    rem_r;
  logic [rsth_pkg::AW-1:0]  den_r;
  logic [31:0]              q_r;
  logic [4:0]               cnt_r;
  logic                     done_r;

  logic [rsth_pkg::AW:0]    rem2;
  logic                     ge;

  // Shift remainder and trial subtract
  always_comb begin
    rem2 = {rem_r[rsth_pkg::AW-1:0], 1'b0};
    ge   = rem2 >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= {1'b0, num};
            den_r   <= den;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? (rem2 - {1'b0, den_r}) : rem2;
          q_r   <= {q_r[30:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== rtl/core/ray_segment_triangle_nearest_hit_unit.sv =====
// Each triangle runs preparation, the normal and both plane distances; only where the
// segment crosses the plane do division, hit point and edge tests follow, ending early on an outside edge.
// One triangle at a time: the next is taken once this one is done, after any wait on a held
// query result; the shared limb-serial multiplier sets the pace.
// A query result goes to an output register; the next triangle is taken meanwhile.
// Reset (synchronous, rst_n low) clears the segment registers, near end and hit flag to zero.
// Depends on rsth_pkg, rsth_mac and rsth_div.
`timescale 1ns / 1ps

module ray_segment_triangle_nearest_hit_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsth_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rsth_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_NRM, S_DOT0, S_DOT1, S_CROSS, S_DIVST, S_DIV,
    S_LERP, S_EPREP, S_EN, S_EDOT, S_HIT, S_FINISH
  } state_t;

  state_t                             state_r;
  rsth_pkg::cvec_t                    start_r, far_r, near_r, x_r;
  rsth_pkg::cvec_t                    va_r, vb_r, vc_r;
  logic                               last_r;
  rsth_pkg::dvec_t                    e1_r, e2_r, ws_r, wq_r, qp_r, ed_r, w_r;
  rsth_pkg::wvec_t                    nrm_r, en_r;
  logic signed [rsth_pkg::AW-1:0]     d0_r, d1_r, dd_r;
  logic [rsth_pkg::AW-1:0]            ad0_r;
  logic [31:0]                        t_r;
  logic                               any_hit_r;
  logic [2:0]                         step_r;
  logic [1:0]                         edge_r;
  logic                               busy_r;
  logic                               out_valid_r;
  rsth_pkg::out_t                     out_data_r;

  rsth_pkg::mac_req_t                 mac_req;
  logic                               mac_start, mac_done, mac_state, mac_last;
  logic signed [rsth_pkg::AccW-1:0]   mac_acc;
  logic                               div_start, div_done;
  logic [31:0]                        div_q;
  logic [rsth_pkg::AW-1:0]            abs_dd;
  logic [1:0]                         comp, sidx;
  logic                               second;
  rsth_pkg::cvec_t                    vi, vj;
  logic                               neg0, zero0, neg1, pos1, seg_cross;

  // Decode step into cross product component and dot axis
  always_comb begin
    comp   = step_r[2:1];
    second = step_r[0];
    sidx   = step_r[1:0];
  end

  // Build the request for the shared multiply-accumulate unit
  always_comb begin
    mac_req   = '0;
    mac_state = 1'b1;
    mac_last  = (step_r == 3'd2);
    case (state_r)
      S_NRM: begin
        mac_req.a     = rsth_pkg::wext(rsth_pkg::dpick(e1_r, rsth_pkg::cross_a(comp, second)));
        mac_req.b     = rsth_pkg::dpick(e2_r, rsth_pkg::cross_b(comp, second));
        mac_req.limbs = 3'd1;
        mac_req.neg   = second;
        mac_req.clr   = !second;
        mac_last      = (step_r == 3'd5);
      end
      S_DOT0, S_DOT1: begin
        mac_req.a     = rsth_pkg::wpick(nrm_r, sidx);
        mac_req.b     = (state_r == S_DOT0) ? rsth_pkg::dpick(ws_r, sidx)
                                            : rsth_pkg::dpick(wq_r, sidx);
        mac_req.limbs = 3'd3;
        mac_req.clr   = (sidx == 2'd0);
      end
      S_LERP: begin
        mac_req.a     = rsth_pkg::wext(rsth_pkg::dpick(qp_r, sidx));
        mac_req.b     = {1'b0, t_r};
        mac_req.limbs = 3'd1;
        mac_req.clr   = 1'b1;
      end
      S_EN: begin
        mac_req.a     = rsth_pkg::wpick(nrm_r, rsth_pkg::cross_a(comp, second));
        mac_req.b     = rsth_pkg::dpick(ed_r, rsth_pkg::cross_b(comp, second));
        mac_req.limbs = 3'd3;
        mac_req.neg   = second;
        mac_req.clr   = !second;
        mac_last      = (step_r == 3'd5);
      end
      S_EDOT: begin
        mac_req.a     = rsth_pkg::wpick(en_r, sidx);
        mac_req.b     = rsth_pkg::dpick(w_r, sidx);
        mac_req.limbs = 3'd4;
        mac_req.clr   = (sidx == 2'd0);
      end
      default: mac_state = 1'b0;
    endcase
    mac_start = mac_state && !busy_r;
  end

  // Edge endpoints, plane crossing test and divider operands
  always_comb begin
    case (edge_r)
      2'd0:    begin vi = va_r; vj = vb_r; end
      2'd1:    begin vi = vb_r; vj = vc_r; end
      default: begin vi = vc_r; vj = va_r; end
    endcase
    neg0      = d0_r[rsth_pkg::AW-1];
    zero0     = (d0_r == '0);
    neg1      = d1_r[rsth_pkg::AW-1];
    pos1      = !neg1 && (d1_r != '0);
    seg_cross = ((neg0 || zero0) && pos1) || (!neg0 && neg1);
    abs_dd    = dd_r[rsth_pkg::AW-1] ? -dd_r : dd_r;
    div_start = (state_r == S_DIVST);
  end

  rsth_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .req   (mac_req),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  rsth_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ad0_r),
    .den   (abs_dd),
    .done  (div_done),
    .q     (div_q)
  );

  // Sequencer, datapath registers, result register and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      any_hit_r   <= 1'b0;
      start_r     <= '0;
      far_r       <= '0;
      near_r      <= '0;
      step_r      <= '0;
      edge_r      <= '0;
    end else begin
      if (out_valid_r && out_ready && !(state_r == S_FINISH && last_r)) out_valid_r <= 1'b0;
      if (mac_start) busy_r <= 1'b1;
      if (mac_done) busy_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            va_r    <= '{in_data.a_x, in_data.a_y, in_data.a_z};
            vb_r    <= '{in_data.b_x, in_data.b_y, in_data.b_z};
            vc_r    <= '{in_data.c_x, in_data.c_y, in_data.c_z};
            last_r  <= in_data.last_triangle;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          e1_r    <= rsth_pkg::vsub(vb_r, va_r);
          e2_r    <= rsth_pkg::vsub(vc_r, va_r);
          ws_r    <= rsth_pkg::vsub(start_r, va_r);
          wq_r    <= rsth_pkg::vsub(near_r, va_r);
          qp_r    <= rsth_pkg::vsub(near_r, start_r);
          step_r  <= '0;
          state_r <= S_NRM;
        end
        S_NRM, S_EN: begin
          if (mac_done) begin
            if (second) begin
              if (state_r == S_NRM) nrm_r <= rsth_pkg::wset(nrm_r, comp,
                                                 mac_acc[rsth_pkg::AW-1:0]);
              else en_r <= rsth_pkg::wset(en_r, comp, mac_acc[rsth_pkg::AW-1:0]);
            end
            if (mac_last) begin
              step_r  <= '0;
              state_r <= (state_r == S_NRM) ? S_DOT0 : S_EDOT;
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end
        S_DOT0, S_DOT1: begin
          if (mac_done) begin
            if (mac_last) begin
              if (state_r == S_DOT0) d0_r <= mac_acc[rsth_pkg::AW-1:0];
              else d1_r <= mac_acc[rsth_pkg::AW-1:0];
              step_r  <= '0;
              state_r <= (state_r == S_DOT0) ? S_DOT1 : S_CROSS;
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end
        S_CROSS: begin
          dd_r    <= d1_r - d0_r;
          ad0_r   <= neg0 ? -d0_r : d0_r;
          state_r <= seg_cross ? S_DIVST : S_FINISH;
        end
        S_DIVST: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            t_r     <= div_q;
            step_r  <= '0;
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          if (mac_done) begin
            case (sidx)
              2'd0:    x_r.x <= start_r.x + mac_acc[63:32];
              2'd1:    x_r.y <= start_r.y + mac_acc[63:32];
              default: x_r.z <= start_r.z + mac_acc[63:32];
            endcase
            if (mac_last) begin
              edge_r  <= '0;
              state_r <= S_EPREP;
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end
        S_EPREP: begin
          ed_r    <= rsth_pkg::vsub(vj, vi);
          w_r     <= rsth_pkg::vsub(x_r, vi);
          step_r  <= '0;
          state_r <= S_EN;
        end
        S_EDOT: begin
          if (mac_done) begin
            if (mac_last) begin
              step_r <= '0;
              // Drop on a negative side distance; after the last edge record a hit, otherwise test the next edge
              if (mac_acc[rsth_pkg::AccW-1]) begin
                state_r <= S_FINISH;
              end else if (edge_r == 2'd2) begin
                state_r <= S_HIT;
              end else begin
                edge_r  <= edge_r + 2'd1;
                state_r <= S_EPREP;
              end
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end
        S_HIT: begin
          near_r    <= x_r;
          any_hit_r <= 1'b1;
          state_r   <= S_FINISH;
        end
        S_FINISH: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{near_r.x, near_r.y, near_r.z, any_hit_r};
            near_r      <= far_r;
            any_hit_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Register writes; a far write also loads the near end
      if (cfg_we) begin
        case (cfg_index)
          rsth_pkg::CFG_START_X: start_r.x <= cfg_data;
          rsth_pkg::CFG_START_Y: start_r.y <= cfg_data;
          rsth_pkg::CFG_START_Z: start_r.z <= cfg_data;
          rsth_pkg::CFG_FAR_X: begin far_r.x <= cfg_data; near_r.x <= cfg_data; end
          rsth_pkg::CFG_FAR_Y: begin far_r.y <= cfg_data; near_r.y <= cfg_data; end
          rsth_pkg::CFG_FAR_Z: begin far_r.z <= cfg_data; near_r.z <= cfg_data; end
          default: ;
        endcase
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Multiplier results come back only for an issued request
  a_mac_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> busy_r) else $error("mac result without request");
  // An accepted triangle starts preparation next cycle
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PREP)) else $error("accept not followed");
  // Divider finishes only while the sequencer waits on it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV)) else $error("divider done out of sequence");
  // No multiplier request is pending while idle
  a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !busy_r) else $error("idle with multiplier busy");
`endif

endmodule

// ===== test/ray_segment_triangle_nearest_hit_unit_checker.sv =====
// Checker for the ray segment / triangle nearest-hit unit: watches the request,
// result and register ports, predicts each query result and compares it.
// Depends on rsth_pkg for the request and result types.
`timescale 1ns / 1ps

module ray_segment_triangle_nearest_hit_unit_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  rsth_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  rsth_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output int             fail_count,
  output int             pending,
  output int             hits_seen
);

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } wvec3_t;

  // Mirrored configuration and segment state
  logic signed [31:0] seg_start [3];
  logic signed [31:0] seg_far   [3];
  logic signed [31:0] near_pt   [3];
  logic               hit_flag;
  rsth_pkg::out_t     hit_queue [$];

  function automatic wide_t widen(input logic signed [31:0] v);
    return v;
  endfunction

  function automatic wvec3_t mk(input logic signed [31:0] x, input logic signed [31:0] y,
                                input logic signed [31:0] z);
    wvec3_t r;
    r.x = widen(x);
    r.y = widen(y);
    r.z = widen(z);
    return r;
  endfunction

  function automatic wvec3_t vdiff(input wvec3_t a, input wvec3_t b);
    wvec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wvec3_t vcross(input wvec3_t u, input wvec3_t v);
    wvec3_t r;
    r.x = u.y * v.z - u.z * v.y;
    r.y = u.z * v.x - u.x * v.z;
    r.z = u.x * v.y - u.y * v.x;
    return r;
  endfunction

  function automatic wide_t vdot(input wvec3_t a, input wvec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic wide_t wabs(input wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  // Advance the nearest-hit state by one triangle; queue a result on the last one
  task automatic trace_triangle(input rsth_pkg::in_t tri_in);
    wvec3_t vt [3];
    wvec3_t p0, q, nrm, xp, m;
    wide_t  off, d0, d1, prod, tw;
    logic [255:0] num, den, quo;
    logic   in_tri;
    rsth_pkg::out_t res;
    vt[0] = mk(tri_in.a_x, tri_in.a_y, tri_in.a_z);
    vt[1] = mk(tri_in.b_x, tri_in.b_y, tri_in.b_z);
    vt[2] = mk(tri_in.c_x, tri_in.c_y, tri_in.c_z);
    p0  = mk(seg_start[0], seg_start[1], seg_start[2]);
    q   = mk(near_pt[0], near_pt[1], near_pt[2]);
    nrm = vcross(vdiff(vt[1], vt[0]), vdiff(vt[2], vt[0]));
    off = vdot(nrm, vt[0]);
    d0  = vdot(nrm, p0) - off;
    d1  = vdot(nrm, q) - off;
    if ((d0 <= 0 && d1 > 0) || (d0 >= 0 && d1 < 0)) begin
      num = wabs(d0);
      den = wabs(d1 - d0);
      quo = (num << 32) / den;
      tw  = {224'd0, quo[31:0]};
      prod = (q.x - p0.x) * tw;
      xp.x = p0.x + (prod >>> 32);
      prod = (q.y - p0.y) * tw;
      xp.y = p0.y + (prod >>> 32);
      prod = (q.z - p0.z) * tw;
      xp.z = p0.z + (prod >>> 32);
      in_tri = 1'b1;
      for (int i = 0; i < 3; i++) begin
        m = vcross(nrm, vdiff(vt[(i + 1) % 3], vt[i]));
        if (vdot(m, xp) - vdot(m, vt[i]) < 0) in_tri = 1'b0;
      end
      if (in_tri) begin
        near_pt[0] = xp.x[31:0];
        near_pt[1] = xp.y[31:0];
        near_pt[2] = xp.z[31:0];
        hit_flag   = 1'b1;
      end
    end
    if (tri_in.last_triangle) begin
      res.hit_x     = near_pt[0];
      res.hit_y     = near_pt[1];
      res.hit_z     = near_pt[2];
      res.hit_found = hit_flag;
      hit_queue = {hit_queue, res};
      near_pt  = seg_far;
      hit_flag = 1'b0;
    end
  endtask

  // Compare one result against the oldest queued one
  task automatic check_hit(input rsth_pkg::out_t got);
    rsth_pkg::out_t want;
    if (hit_queue.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      fail_count++;
    end else begin
      want = hit_queue.pop_front();
      if (got.hit_x !== want.hit_x || got.hit_y !== want.hit_y ||
          got.hit_z !== want.hit_z || got.hit_found !== want.hit_found) begin
        $display("%0t: mismatch expected x=%h y=%h z=%h found=%b actual x=%h y=%h z=%h found=%b",
                 $time, want.hit_x, want.hit_y, want.hit_z, want.hit_found,
                 got.hit_x, got.hit_y, got.hit_z, got.hit_found);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    hits_seen  = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        seg_start[k] = '0;
        seg_far[k]   = '0;
        near_pt[k]   = '0;
      end
      hit_flag = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rsth_pkg::CFG_START_X: seg_start[0] = cfg_data;
          rsth_pkg::CFG_START_Y: seg_start[1] = cfg_data;
          rsth_pkg::CFG_START_Z: seg_start[2] = cfg_data;
          rsth_pkg::CFG_FAR_X: begin
            seg_far[0] = cfg_data;
            near_pt[0] = cfg_data;
          end
          rsth_pkg::CFG_FAR_Y: begin
            seg_far[1] = cfg_data;
            near_pt[1] = cfg_data;
          end
          rsth_pkg::CFG_FAR_Z: begin
            seg_far[2] = cfg_data;
            near_pt[2] = cfg_data;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) trace_triangle(in_data);
      if (out_valid && out_ready) begin
        check_hit(out_data);
        hits_seen++;
      end
      pending = hit_queue.size();
    end
  end

endmodule

// ===== test/ray_segment_triangle_nearest_hit_unit_tb.sv =====
// Testbench top for the ray segment / triangle nearest-hit unit: clock, reset,
// register setup, triangle requests and result back-pressure, plus the verdict.
// Depends on rsth_pkg, the unit itself and ray_segment_triangle_nearest_hit_unit_checker.
`timescale 1ns / 1ps

module ray_segment_triangle_nearest_hit_unit_tb;

  localparam int          CycleLimit  = 3000000;
  localparam int          DrainCycles = 400;
  localparam logic [2:0]  CFG_SPARE_A = 3'd6;
  localparam logic [2:0]  CFG_SPARE_B = 3'd7;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  rsth_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rsth_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [2:0]     cfg_index = '0;
  logic [31:0]    cfg_data = '0;
  int             fail_count, pending, hits_seen;
  int             cycles = 0;
  logic           stall_done = 1'b0;

  // Current segment, used to aim triangles
  longint sx, sy, sz, fx, fy, fz;

  always #4 clk = ~clk;

  ray_segment_triangle_nearest_hit_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ray_segment_triangle_nearest_hit_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .hits_seen(hits_seen)
  );

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ray_segment_triangle_nearest_hit_unit test failed");
      $finish;
    end
  end

  function automatic int rnd_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic rsth_pkg::in_t mk_tri(input longint ax, input longint ay,
                                           input longint az, input longint bx,
                                           input longint by, input longint bz,
                                           input longint cx, input longint cy,
                                           input longint cz, input logic last);
    rsth_pkg::in_t t;
    t.a_x = ax[31:0]; t.a_y = ay[31:0]; t.a_z = az[31:0];
    t.b_x = bx[31:0]; t.b_y = by[31:0]; t.b_z = bz[31:0];
    t.c_x = cx[31:0]; t.c_y = cy[31:0]; t.c_z = cz[31:0];
    t.last_triangle = last;
    return t;
  endfunction

  // Offer one triangle request after a random gap and hold it until taken
  task automatic send_tri(input rsth_pkg::in_t t);
    int gap;
    gap = $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_data  = t;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain, let the block settle, then load a new segment
  task automatic set_segment(input longint ax, input longint ay, input longint az,
                             input longint bx, input longint by, input longint bz);
    logic [31:0] vals [6];
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk);
    vals[0] = ax[31:0]; vals[1] = ay[31:0]; vals[2] = az[31:0];
    vals[3] = bx[31:0]; vals[4] = by[31:0]; vals[5] = bz[31:0];
    sx = $signed(vals[0]); sy = $signed(vals[1]); sz = $signed(vals[2]);
    fx = $signed(vals[3]); fy = $signed(vals[4]); fz = $signed(vals[5]);
    for (int i = 0; i < 6; i++) begin
      cfg_we    = 1'b1;
      cfg_index = rsth_pkg::cfg_idx_t'(i);
      cfg_data  = vals[i];
      @(negedge clk);
    end
    // Spare indexes must be ignored
    cfg_index = CFG_SPARE_A;
    cfg_data  = $urandom;
    @(negedge clk);
    cfg_index = CFG_SPARE_B;
    cfg_data  = $urandom;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Build one triangle of a query: mostly aimed at the segment, some noise
  function automatic rsth_pkg::in_t rand_tri(input logic last);
    int     kind;
    longint px, py, pz, ux, uy, uz, wx, wy, wz;
    int     k;
    kind = $urandom_range(0, 9);
    ux = rnd_span(1 << 22); uy = rnd_span(1 << 22); uz = rnd_span(1 << 22);
    wx = rnd_span(1 << 22); wy = rnd_span(1 << 22); wz = rnd_span(1 << 22);
    k  = $urandom_range(1, 7);
    px = sx + ((fx - sx) * k) / 8;
    py = sy + ((fy - sy) * k) / 8;
    pz = sz + ((fz - sz) * k) / 8;
    case (kind)
      0: return mk_tri($signed($urandom), $signed($urandom), $signed($urandom),
                       $signed($urandom), $signed($urandom), $signed($urandom),
                       $signed($urandom), $signed($urandom), $signed($urandom), last);
      1: return mk_tri(px + ux, py + uy, pz + uz, px + wx, py + wy, pz + wz,
                       px + ux, py + uy, pz + uz, last);
      2: return mk_tri(sx + ux, sy + uy, sz + uz, sx + wx, sy + wy, sz + wz,
                       sx - ux - wx, sy - uy - wy, sz - uz - wz, last);
      default: return mk_tri(px + ux, py + uy, pz + uz, px + wx, py + wy, pz + wz,
                             px - ux - wx, py - uy - wy, pz - uz - wz, last);
    endcase
  endfunction

  // Result side: random back-pressure and one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (!stall_done && hits_seen >= 12) begin
        stall_done = 1'b1;
        @(negedge clk);
        out_ready = 1'b0;
        repeat (3000) @(negedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    int n;
    sx = 0; sy = 0; sz = 0; fx = 0; fy = 0; fz = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset segment is a single point: nothing can cross
    send_tri(mk_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 1'b0));
    send_tri(mk_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1));

    // Simple z-axis segment through the z=0 plane
    set_segment(0, 0, -(10 <<< 16), 0, 0, 10 <<< 16);
    send_tri(mk_tri(-(1 <<< 16), -(1 <<< 16), 0, 2 <<< 16, -(1 <<< 16), 0,
                    -(1 <<< 16), 2 <<< 16, 0, 1'b1));
    send_tri(mk_tri(5 <<< 16, 5 <<< 16, 0, 8 <<< 16, 5 <<< 16, 0,
                    5 <<< 16, 8 <<< 16, 0, 1'b1));
    send_tri(mk_tri(1, 1, 5, 1, 1, 5, 1, 1, 5, 1'b1));
    send_tri(mk_tri(-(1 <<< 16), -(1 <<< 16), 3 <<< 16, 2 <<< 16, -(1 <<< 16), 3 <<< 16,
                    -(1 <<< 16), 2 <<< 16, 3 <<< 16, 1'b0));
    send_tri(mk_tri(-(1 <<< 16), -(1 <<< 16), -(2 <<< 16), 2 <<< 16, -(1 <<< 16),
                    -(2 <<< 16), -(1 <<< 16), 2 <<< 16, -(2 <<< 16), 1'b0));
    send_tri(mk_tri(-(1 <<< 16), -(1 <<< 16), 7 <<< 16, 2 <<< 16, -(1 <<< 16), 7 <<< 16,
                    -(1 <<< 16), 2 <<< 16, 7 <<< 16, 1'b1));
    // Plane through the start point: hit with zero parameter
    send_tri(mk_tri(-(1 <<< 16), -(1 <<< 16), -(10 <<< 16), 2 <<< 16, -(1 <<< 16),
                    -(10 <<< 16), -(1 <<< 16), 2 <<< 16, -(10 <<< 16), 1'b1));

    // Extreme segments
    set_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    for (int i = 0; i < 4; i++) send_tri(rand_tri(i == 3));
    send_tri(mk_tri(CMAX, CMIN, 0, CMIN, CMAX, 0, CMIN, CMIN, CMAX, 1'b1));
    set_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    for (int i = 0; i < 4; i++) send_tri(rand_tri(i == 3));
    send_tri(mk_tri(CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, 1'b1));

    // Random phases: short queries of aimed triangles with noise mixed in
    for (int ph = 0; ph < 32; ph++) begin
      if (ph % 8 == 7)
        set_segment($signed($urandom), $signed($urandom), $signed($urandom),
                    $signed($urandom), $signed($urandom), $signed($urandom));
      else
        set_segment(rnd_span(1 << 26), rnd_span(1 << 26), rnd_span(1 << 26),
                    rnd_span(1 << 26), rnd_span(1 << 26), rnd_span(1 << 26));
      for (int qn = 0; qn < 5; qn++) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_tri(rand_tri(i == n - 1));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("ray_segment_triangle_nearest_hit_unit test passed");
    end else begin
      $display("ray_segment_triangle_nearest_hit_unit test failed");
    end
    $finish;
  end

endmodule

// ===== ray_segment_triangle_nearest_hit_unit.f =====
rtl/core/rsth_pkg.sv
rtl/core/rsth_mac.sv
rtl/core/rsth_div.sv
rtl/core/ray_segment_triangle_nearest_hit_unit.sv
test/ray_segment_triangle_nearest_hit_unit_checker.sv
test/ray_segment_triangle_nearest_hit_unit_tb.sv
